[rtl/core/hsvrgb_pkg.sv]
package hsvrgb_pkg;

    localparam int unsigned PWM_WIDTH_DEF = 16;

    localparam int unsigned CFG_NUM = 8;
    localparam int unsigned CFG_IW  = 3;

    localparam logic [CFG_IW-1:0] CFG_THRESHOLD      = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RED_GAIN_BR    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BLUE_GAIN_BR   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_RED_GAIN_DIM   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_BLUE_GAIN_DIM  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_RED_SLOPE      = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_BLUE_SLOPE     = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_PWM_FULL_SCALE = 3'd7;

    typedef logic [15:0] t_cfg_arr [CFG_NUM];

    localparam t_cfg_arr CFG_RESET = '{
        16'd0, 16'd4096, 16'd4096, 16'd3686, 16'd4710, 16'd0, 16'd0, 16'd1023
    };

    localparam logic [20:0] SECT_SPAN  = 21'd1966080;
    localparam logic [16:0] Q15_ONE    = 17'd32768;
    localparam logic [19:0] DIV15_MUL  = 20'((1 << 23) / 15 + 1);

    localparam int unsigned DIV_QW = 16;
    localparam int unsigned DIV_DW = 28;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    localparam int unsigned SAT_CURVE [0:100] = '{
        0, 15, 30, 45, 60, 75, 90, 105, 120, 135,
        150, 165, 180, 195, 210, 225, 240, 255, 270, 285,
        300, 315, 330, 345, 360, 375, 390, 405, 420, 435,
        450, 465, 480, 495, 510, 525, 540, 555, 570, 585,
        600, 610, 620, 630, 640, 650, 650, 670, 680, 690,
        700, 710, 720, 730, 740, 750, 760, 770, 780, 790,
        800, 805, 810, 815, 820, 825, 830, 835, 840, 845,
        850, 855, 860, 865, 870, 875, 880, 885, 890, 895,
        900, 905, 910, 915, 920, 925, 930, 935, 940, 945,
        950, 955, 960, 965, 970, 975, 980, 985, 990, 995, 1000
    };

    typedef logic [15:0] t_sat_tab [0:100];

    function automatic t_sat_tab f_sat_build();
        t_sat_tab tab;
        for (int i = 0; i <= 100; i++) begin
            tab[i] = 16'((SAT_CURVE[i] * 32768 + 500) / 1000);
        end
        return tab;
    endfunction

    localparam t_sat_tab SAT_Q15 = f_sat_build();

endpackage

[rtl/core/hsvrgb_div.sv]
module hsvrgb_div
    import hsvrgb_pkg::*;
#(
    parameter int unsigned QW = DIV_QW,
    parameter int unsigned DW = DIV_DW
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DW+QW-1:0]  i_num,
    input  logic [DW-1:0]     i_den,
    output logic [QW-1:0]     o_quo
);

    localparam int unsigned RW = DW + QW;

    logic [RW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [RW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [RW-1:0] dsh;
            logic [RW-1:0] n_rem;
            logic [QW-1:0] n_quo;

            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
                assign quo_in = r_quo[k-1];
            end

            always_comb begin
                dsh   = RW'(den_in) << (QW - 1 - k);
                n_rem = rem_in;
                n_quo = quo_in;
                if (rem_in >= dsh) begin
                    n_rem = rem_in - dsh;
                    n_quo[QW-1-k] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                    r_quo[k] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];

endmodule

[rtl/core/hsv_to_rgb_led_pwm_balance_unit.sv]
// HSV to RGB converter for an RGB LED driver with red and blue balance against green and
// PWM scaling. One color enters per clock on the input stream and one result of three
// counts leaves per clock while the output skid register is empty; a result passes through
// nine arithmetic stages, a 16-stage one-bit-per-stage divider for the renormalization,
// and a final clamp stage. An output skid register lets the pipeline take one more
// input while a result waits. Configuration writes are taken at any time but must only
// be made while the pipeline holds no item.
module hsv_to_rgb_led_pwm_balance_unit
    import hsvrgb_pkg::*;
#(
    parameter int unsigned PWM_WIDTH = PWM_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // hue[8:0], saturation_percent[15:9], brightness[31:16]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [47:0]       o_m_tdata,   // red_count[15:0], green_count[31:16], blue_count[47:32]
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int unsigned FRONT = 9;
    localparam int unsigned NST   = FRONT + DIV_QW + 1;
    localparam int unsigned RW    = DIV_DW + DIV_QW;
    localparam logic [16:0] CNT_TOP = (17'd1 << PWM_WIDTH) - 17'd1;

    logic [15:0] r_cfg [CFG_NUM];
    logic        en;
    logic [NST-1:0] r_vld;
    logic        r_skid_v;
    logic [47:0] r_skid_data;

    assign o_cfg_ready = 1'b1;
    assign en = !r_skid_v;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Stage 1: input clamps.
    logic [8:0]  r1_h;
    logic [6:0]  r1_idx;
    logic [15:0] r1_v;
    logic [8:0]  in_h;
    logic [6:0]  in_idx;
    logic [15:0] in_v;

    assign in_h   = i_s_tdata[8:0];
    assign in_idx = i_s_tdata[15:9];
    assign in_v   = i_s_tdata[31:16];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_h   <= (in_h >= 9'd360) ? 9'd0 : in_h;
            r1_idx <= (in_idx > 7'd100) ? 7'd100 : in_idx;
            r1_v   <= (in_v > 16'd32768) ? 16'd32768 : in_v;
        end
    end

    // Stage 2: sector, saturation and gain selection terms.
    t_sector     c2_sec;
    logic [8:0]  c2_base;
    logic [5:0]  c2_rem;
    logic [15:0] c2_s;
    logic [21:0] c2_rs1;
    logic [21:0] c2_rs2;
    t_sector     r2_sec;
    logic [15:0] r2_v;
    logic [16:0] r2_ps;
    logic [20:0] r2_a1;
    logic [20:0] r2_a2;
    logic [15:0] r2_gap;
    logic        r2_bright;

    always_comb begin
        if (r1_h < 9'd60) begin
            c2_sec = SEC_0;  c2_base = 9'd0;
        end else if (r1_h < 9'd120) begin
            c2_sec = SEC_1;  c2_base = 9'd60;
        end else if (r1_h < 9'd180) begin
            c2_sec = SEC_2;  c2_base = 9'd120;
        end else if (r1_h < 9'd240) begin
            c2_sec = SEC_3;  c2_base = 9'd180;
        end else if (r1_h < 9'd300) begin
            c2_sec = SEC_4;  c2_base = 9'd240;
        end else begin
            c2_sec = SEC_5;  c2_base = 9'd300;
        end
        c2_rem = 6'(r1_h - c2_base);
        c2_s   = SAT_Q15[r1_idx];
        c2_rs1 = 22'(c2_rem) * 22'(c2_s);
        c2_rs2 = 22'(6'd60 - c2_rem) * 22'(c2_s);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sec    <= c2_sec;
            r2_v      <= r1_v;
            r2_ps     <= Q15_ONE - 17'(c2_s);
            r2_a1     <= 21'(22'(SECT_SPAN) - c2_rs1);
            r2_a2     <= 21'(22'(SECT_SPAN) - c2_rs2);
            r2_gap    <= r_cfg[CFG_THRESHOLD] - r1_v;
            r2_bright <= (r1_v >= r_cfg[CFG_THRESHOLD]);
        end
    end

    // Stage 3: products of brightness, and the dim gains.
    logic [31:0] c3_pm;
    logic [36:0] c3_qm;
    logic [36:0] c3_tm;
    logic [31:0] c3_sr;
    logic [31:0] c3_sb;
    t_sector     r3_sec;
    logic [15:0] r3_v;
    logic [15:0] r3_p;
    logic [20:0] r3_qy;
    logic [20:0] r3_ty;
    logic [17:0] r3_gr;
    logic [17:0] r3_gb;

    always_comb begin
        c3_pm = 32'(r2_v) * 32'(r2_ps);
        c3_qm = 37'(r2_v) * 37'(r2_a1);
        c3_tm = 37'(r2_v) * 37'(r2_a2);
        c3_sr = 32'(r_cfg[CFG_RED_SLOPE]) * 32'(r2_gap);
        c3_sb = 32'(r_cfg[CFG_BLUE_SLOPE]) * 32'(r2_gap);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sec <= r2_sec;
            r3_v   <= r2_v;
            r3_p   <= 16'(c3_pm >> 15);
            r3_qy  <= 21'(c3_qm >> 15);
            r3_ty  <= 21'(c3_tm >> 15);
            r3_gr  <= r2_bright ? 18'(r_cfg[CFG_RED_GAIN_BR])
                                : 18'(r_cfg[CFG_RED_GAIN_DIM]) + 18'(c3_sr >> 15);
            r3_gb  <= r2_bright ? 18'(r_cfg[CFG_BLUE_GAIN_BR])
                                : 18'(r_cfg[CFG_BLUE_GAIN_DIM]) + 18'(c3_sb >> 15);
        end
    end

    // Stage 4: division by 60 through a reciprocal.
    logic [38:0] c4_qd;
    logic [38:0] c4_td;
    t_sector     r4_sec;
    logic [15:0] r4_v;
    logic [15:0] r4_p;
    logic [15:0] r4_q;
    logic [15:0] r4_t;
    logic [17:0] r4_gr;
    logic [17:0] r4_gb;

    always_comb begin
        c4_qd = 39'(r3_qy[20:2]) * 39'(DIV15_MUL);
        c4_td = 39'(r3_ty[20:2]) * 39'(DIV15_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sec <= r3_sec;
            r4_v   <= r3_v;
            r4_p   <= r3_p;
            r4_q   <= 16'(c4_qd >> 23);
            r4_t   <= 16'(c4_td >> 23);
            r4_gr  <= r3_gr;
            r4_gb  <= r3_gb;
        end
    end

    // Stage 5: sector select.
    logic [15:0] c5_r;
    logic [15:0] c5_g;
    logic [15:0] c5_b;
    logic [15:0] r5_r;
    logic [15:0] r5_g;
    logic [15:0] r5_b;
    logic [15:0] r5_v;
    logic [17:0] r5_gr;
    logic [17:0] r5_gb;

    always_comb begin
        case (r4_sec)
            SEC_0: begin
                c5_r = r4_v;  c5_g = r4_t;  c5_b = r4_p;
            end
            SEC_1: begin
                c5_r = r4_q;  c5_g = r4_v;  c5_b = r4_p;
            end
            SEC_2: begin
                c5_r = r4_p;  c5_g = r4_v;  c5_b = r4_t;
            end
            SEC_3: begin
                c5_r = r4_p;  c5_g = r4_q;  c5_b = r4_v;
            end
            SEC_4: begin
                c5_r = r4_t;  c5_g = r4_p;  c5_b = r4_v;
            end
            default: begin
                c5_r = r4_v;  c5_g = r4_p;  c5_b = r4_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_r  <= c5_r;
            r5_g  <= c5_g;
            r5_b  <= c5_b;
            r5_v  <= r4_v;
            r5_gr <= r4_gr;
            r5_gb <= r4_gb;
        end
    end

    // Stage 6: balance gains and brightness times full scale.
    logic [33:0] c6_rw;
    logic [33:0] c6_bw;
    logic [20:0] r6_x [3];
    logic [31:0] r6_k1;

    always_comb begin
        c6_rw = 34'(r5_r) * 34'(r5_gr);
        c6_bw = 34'(r5_b) * 34'(r5_gb);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_x[0] <= 21'(c6_rw >> 12);
            r6_x[1] <= 21'(r5_g);
            r6_x[2] <= 21'(c6_bw >> 12);
            r6_k1   <= 32'(r5_v) * 32'(r_cfg[CFG_PWM_FULL_SCALE]);
        end
    end

    // Stage 7: channel sum and numerator factor times 19.
    logic [20:0] r7_x [3];
    logic [22:0] r7_t;
    logic [36:0] r7_k;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_x <= r6_x;
            r7_t <= 23'(r6_x[0]) + 23'(r6_x[1]) + 23'(r6_x[2]);
            r7_k <= (37'(r6_k1) << 4) + (37'(r6_k1) << 1) + 37'(r6_k1);
        end
    end

    // Stage 8: partial products of the numerators, denominator times 20.
    logic [41:0] r8_xh [3];
    logic [36:0] r8_xl [3];
    logic [DIV_DW-1:0] r8_d;
    logic        r8_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_xh[i] <= 42'(r7_x[i]) * 42'(r7_k[36:16]);
                r8_xl[i] <= 37'(r7_x[i]) * 37'(r7_k[15:0]);
            end
            r8_d    <= (DIV_DW'(r7_t) << 4) + (DIV_DW'(r7_t) << 2);
            r8_zero <= (r7_t == 23'd0);
        end
    end

    // Stage 9: numerators assembled and scaled down by 2^15.
    logic [RW-1:0]     r9_n [3];
    logic [DIV_DW-1:0] r9_d;
    logic [DIV_QW:0]   r_zero_dly;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r9_n[i] <= RW'(((58'(r8_xh[i]) << 16) + 58'(r8_xl[i])) >> 15);
            end
            r9_d       <= r8_d;
            r_zero_dly <= {r_zero_dly[DIV_QW-1:0], r8_zero};
        end
    end

    logic [DIV_QW-1:0] quo [3];

    genvar ln;
    generate
        for (ln = 0; ln < 3; ln++) begin : g_lane
            hsvrgb_div #(
                .QW (DIV_QW),
                .DW (DIV_DW)
            ) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r9_n[ln]),
                .i_den (r9_d),
                .o_quo (quo[ln])
            );
        end
    endgenerate

    // Final stage: minimum count, saturation and the zero-sum case.
    logic [15:0] r_cnt [3];
    logic [15:0] c_cnt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_cnt[i] = 16'(quo[i]);
            if (c_cnt[i] != 16'd0 && c_cnt[i] < 16'd8) begin
                c_cnt[i] = 16'd8;
            end
            if (17'(c_cnt[i]) > CNT_TOP) begin
                c_cnt[i] = 16'(CNT_TOP);
            end
            if (r_zero_dly[DIV_QW]) begin
                c_cnt[i] = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cnt <= c_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    logic [47:0] last_data;
    assign last_data = {r_cnt[2], r_cnt[1], r_cnt[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_vld[NST-1] && !i_m_tready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_data <= last_data;
        end
    end

    assign o_m_tvalid = r_skid_v || r_vld[NST-1];
    assign o_m_tdata  = r_skid_v ? r_skid_data : last_data;

endmodule
